[rtl/pfnm_pkg.sv]
// Package for the power-flow node mismatch block: constants, types, helpers.
// No dependencies.
package pfnm_pkg;

    localparam int FRAC_BITS_DEF    = 24;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic signed [35:0] PI_Q30    = 36'sd3373259426;
    localparam logic signed [35:0] KGAIN_Q30 = 36'sd652032874;

    // Input word command codes
    typedef enum logic [0:0] {
        CMD_HEADER = 1'b0,
        CMD_EDGE   = 1'b1
    } cmd_code_t;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 36'sd843314857;
            5'd1:  atan_q30 = 36'sd497837829;
            5'd2:  atan_q30 = 36'sd263043837;
            5'd3:  atan_q30 = 36'sd133525159;
            5'd4:  atan_q30 = 36'sd67021687;
            5'd5:  atan_q30 = 36'sd33543516;
            5'd6:  atan_q30 = 36'sd16775851;
            5'd7:  atan_q30 = 36'sd8388437;
            5'd8:  atan_q30 = 36'sd4194283;
            5'd9:  atan_q30 = 36'sd2097149;
            default: atan_q30 = 36'sd1 <<< (5'd30 - i);
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
        if (x > 42'sd2147483647)       sat32 = 32'sh7fffffff;
        else if (x < -42'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = x[31:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [41:0] x);
        if (x > 42'sd549755813887)       sat40 = 40'sh7fffffffff;
        else if (x < -42'sd549755813888) sat40 = 40'sh8000000000;
        else                             sat40 = x[39:0];
    endfunction

endpackage

[rtl/power_flow_node_mismatch_top.sv]
// Top level of the power-flow node mismatch block: sequencer, shared multiplier,
// accumulators and output register. Depends on pfnm_pkg and pfnm_cordic.
//
//   port group   dir   content
//   s_*          in    header or edge word (cmd, last, volt, angle, G, B, P, Q, dir)
//   m_*          out   edge Jacobian entries or bus totals
//
// Header word: multiplier steps, then back to idle. Edge word: sin/cos from the
// CORDIC, then multiplier steps and one step to load the result. A last word adds
// one totals word. s_ready is low while a word is in work or a result is held;
// m_valid holds until taken. Reset is synchronous, aresetn low.
module power_flow_node_mismatch_top
    import pfnm_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic               s_last,
    input  logic signed [31:0] s_volt,
    input  logic signed [31:0] s_angle,
    input  logic signed [31:0] s_cond,
    input  logic signed [31:0] s_susc,
    input  logic signed [31:0] s_boundary_p,
    input  logic signed [31:0] s_boundary_q,
    input  logic               s_edge_ends_here,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic               m_done_res,
    output logic signed [31:0] m_p_mismatch,
    output logic signed [31:0] m_q_mismatch,
    output logic signed [31:0] m_dp_dv_self,
    output logic signed [31:0] m_dp_dangle_self,
    output logic signed [31:0] m_dq_dv_self,
    output logic signed [31:0] m_dq_dangle_self,
    output logic signed [31:0] m_dp_dv_other,
    output logic signed [31:0] m_dp_dangle_other,
    output logic signed [31:0] m_dq_dv_other,
    output logic signed [31:0] m_dq_dangle_other
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CORD = 6'b000010,
        S_MUL  = 6'b000100,
        S_EDGE = 6'b001000,
        S_TOT  = 6'b010000,
        S_WAIT = 6'b100000
    } state_t;

    state_t             st_reg, st_next;
    logic [3:0]         step_reg, step_next;
    logic               cmd_reg, last_reg, ends_reg;
    logic signed [31:0] v_reg, ang_reg, g_reg, b_reg, bp_reg, bq_reg;
    logic signed [31:0] bus_volt_reg, bus_angle_reg;
    logic signed [39:0] psum_reg, qsum_reg, dpdv_reg, dpda_reg, dqdv_reg, dqda_reg;
    logic signed [31:0] c_reg, s_reg, gc_reg, gs_reg, bc_reg, bs_reg, vv_reg;
    logic signed [31:0] t0_reg, prod_reg;
    logic signed [31:0] o_reg [4];
    logic               mv_reg, mkind_reg, mdone_reg;
    logic               is_edge, s_is_edge;

    logic               cord_start, cord_done;
    logic signed [31:0] cord_c, cord_s;

    assign is_edge   = (cmd_reg == CMD_EDGE);
    assign s_is_edge = (s_cmd == CMD_EDGE);

    pfnm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .phi     (33'(bus_angle_reg) - 33'(ang_reg)),
        .done    (cord_done),
        .cos_out (cord_c),
        .sin_out (cord_s)
    );

    // shared multiplier operands picked by step
    logic signed [31:0] ma, mb, ta, tb, tcm, tdm, tem, fm;
    logic signed [63:0] pr, pq;
    always_comb begin
        ta  = sat32(42'(gc_reg) + 42'(bs_reg));
        tb  = sat32(42'(gs_reg) - 42'(bc_reg));
        tcm = sat32(42'(bc_reg) - 42'(gs_reg));
        tdm = sat32(42'(gs_reg) + 42'(bc_reg));
        tem = sat32(42'(gc_reg) - 42'(bs_reg));
        ma = v_reg; mb = g_reg;
        if (is_edge) begin
            case (step_reg)
                4'd0:  begin ma = g_reg;        mb = c_reg; end
                4'd1:  begin ma = g_reg;        mb = s_reg; end
                4'd2:  begin ma = b_reg;        mb = c_reg; end
                4'd3:  begin ma = b_reg;        mb = s_reg; end
                4'd4:  begin ma = bus_volt_reg; mb = v_reg; end
                4'd5:  begin ma = vv_reg;       mb = ends_reg ? tem : ta; end
                4'd6:  begin ma = vv_reg;       mb = tb; end
                4'd7:  begin ma = v_reg;        mb = ta; end
                4'd8:  begin ma = vv_reg;       mb = tcm; end
                4'd9:  begin ma = v_reg;        mb = tb; end
                4'd10: begin ma = vv_reg;       mb = ta; end
                4'd11: begin ma = bus_volt_reg; mb = ta; end
                4'd12: begin ma = vv_reg;       mb = tdm; end
                4'd13: begin ma = bus_volt_reg; mb = tb; end
                default: begin ma = vv_reg;     mb = ta; end
            endcase
        end else begin
            case (step_reg)
                4'd0:    begin ma = g_reg;  mb = v_reg; end
                4'd1:    begin ma = b_reg;  mb = v_reg; end
                4'd2:    begin ma = t0_reg; mb = v_reg; end
                default: begin ma = prod_reg; mb = v_reg; end
            endcase
        end
        pr = ma * mb;
        pq = (pr + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (pq > 64'sd2147483647)       fm = 32'sh7fffffff;
        else if (pq < -64'sd2147483648) fm = 32'sh80000000;
        else                            fm = pq[31:0];
    end

    logic [3:0] last_step;
    assign last_step  = is_edge ? 4'd14 : 4'd3;
    assign cord_start = (st_reg == S_CORD) && (step_reg == 4'd0);
    assign s_ready    = (st_reg == S_IDLE) && !mv_reg;

    always_comb begin
        st_next   = st_reg;
        step_next = step_reg;
        case (st_reg)
            S_IDLE: if (s_valid && s_ready) begin
                step_next = '0;
                st_next   = s_is_edge ? S_CORD : S_MUL;
            end
            S_CORD: begin
                step_next = 4'd1;
                if (cord_done) begin
                    step_next = '0;
                    st_next   = S_MUL;
                end
            end
            S_MUL: begin
                step_next = step_reg + 4'd1;
                if (step_reg == last_step) begin
                    if (is_edge)       st_next = S_EDGE;
                    else if (last_reg) st_next = S_TOT;
                    else               st_next = S_IDLE;
                end
            end
            S_EDGE: st_next = last_reg ? S_WAIT : S_IDLE;
            S_WAIT: if (!mv_reg) st_next = S_TOT;
            S_TOT:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_IDLE;
            step_reg      <= '0;
            mv_reg        <= 1'b0;
            bus_volt_reg  <= '0;
            bus_angle_reg <= '0;
            psum_reg <= '0; qsum_reg <= '0; dpdv_reg <= '0;
            dpda_reg <= '0; dqdv_reg <= '0; dqda_reg <= '0;
        end else begin
            st_reg   <= st_next;
            step_reg <= step_next;
            if (m_valid && m_ready) mv_reg <= 1'b0;
            if (st_reg == S_IDLE && s_valid && s_ready) begin
                if (!s_is_edge) begin
                    bus_volt_reg  <= s_volt;
                    bus_angle_reg <= s_angle;
                end
            end
            if (st_reg == S_MUL) begin
                if (!is_edge) begin
                    case (step_reg)
                        4'd0: dpdv_reg <= 40'(sat32(42'(fm) <<< 1));
                        4'd1: dqdv_reg <= 40'(sat32(-(42'(fm) <<< 1)));
                        4'd2: psum_reg <= sat40(-42'(bp_reg) + 42'(fm));
                        default: begin
                            qsum_reg <= sat40(-42'(bq_reg) - 42'(fm));
                            dpda_reg <= '0;
                            dqda_reg <= '0;
                        end
                    endcase
                end else begin
                    case (step_reg)
                        4'd5:  psum_reg <= sat40(42'(psum_reg) + 42'(fm));
                        4'd6:  qsum_reg <= sat40(42'(qsum_reg) + 42'(fm));
                        4'd7:  dpdv_reg <= sat40(42'(dpdv_reg) + 42'(fm));
                        4'd8:  dpda_reg <= sat40(42'(dpda_reg) + 42'(fm));
                        4'd9:  dqdv_reg <= sat40(42'(dqdv_reg) + 42'(fm));
                        4'd10: dqda_reg <= sat40(42'(dqda_reg) + 42'(fm));
                        default: ;
                    endcase
                end
            end
            if (st_reg == S_EDGE || st_reg == S_TOT) mv_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && s_valid && s_ready) begin
            cmd_reg  <= s_cmd;
            last_reg <= s_last;
            ends_reg <= s_edge_ends_here;
            v_reg    <= s_volt;
            ang_reg  <= s_angle;
            g_reg    <= s_cond;
            b_reg    <= s_susc;
            bp_reg   <= s_boundary_p;
            bq_reg   <= s_boundary_q;
        end
        if (st_reg == S_CORD && cord_done) begin
            c_reg <= cord_c;
            s_reg <= cord_s;
        end
        if (st_reg == S_MUL) begin
            // hold B*V for the header's last product
            if (!is_edge && step_reg == 4'd1) prod_reg <= fm;
            if (!is_edge && step_reg == 4'd0) t0_reg <= fm;
            if (is_edge) begin
                case (step_reg)
                    4'd0:  gc_reg   <= fm;
                    4'd1:  gs_reg   <= fm;
                    4'd2:  bc_reg   <= fm;
                    4'd3:  bs_reg   <= fm;
                    4'd4:  vv_reg   <= fm;
                    4'd11: o_reg[0] <= fm;
                    4'd12: o_reg[1] <= fm;
                    4'd13: o_reg[2] <= fm;
                    4'd14: o_reg[3] <= sat32(-42'(fm));
                    default: ;
                endcase
            end
        end
        if (st_reg == S_EDGE) begin
            mkind_reg <= 1'b0;
            mdone_reg <= 1'b0;
        end
        if (st_reg == S_TOT) begin
            mkind_reg <= 1'b1;
            mdone_reg <= 1'b1;
        end
    end

    assign m_valid    = mv_reg;
    assign m_kind     = mkind_reg;
    assign m_done_res = mdone_reg;
    assign m_p_mismatch      = mkind_reg ? sat32(42'(psum_reg)) : '0;
    assign m_q_mismatch      = mkind_reg ? sat32(42'(qsum_reg)) : '0;
    assign m_dp_dv_self      = mkind_reg ? sat32(42'(dpdv_reg)) : '0;
    assign m_dp_dangle_self  = mkind_reg ? sat32(42'(dpda_reg)) : '0;
    assign m_dq_dv_self      = mkind_reg ? sat32(42'(dqdv_reg)) : '0;
    assign m_dq_dangle_self  = mkind_reg ? sat32(42'(dqda_reg)) : '0;
    assign m_dp_dv_other     = mkind_reg ? '0 : o_reg[0];
    assign m_dp_dangle_other = mkind_reg ? '0 : o_reg[1];
    assign m_dq_dv_other     = mkind_reg ? '0 : o_reg[2];
    assign m_dq_dangle_other = mkind_reg ? '0 : o_reg[3];

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != S_IDLE) |-> !s_ready) else $error("input taken while busy");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_tot_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == m_done_res)) else $error("done flag mismatch");

endmodule

[rtl/pfnm_cordic.sv]
// Iterative rotation-mode CORDIC giving cos and sin of a Q8.24-style angle.
// Depends on pfnm_pkg.
module pfnm_cordic
    import pfnm_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] phi,
    output logic               done,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);
    localparam int STEPS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
    localparam int SH    = 30 - FRAC_BITS;
    // wide enough for the scaled angle and for 2*pi*2^SH
    localparam int MW    = 35 + SH;

    typedef logic signed [MW-1:0] wide_t;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_RED  = 4'b0010,
        C_ROT  = 4'b0100,
        C_OUT  = 4'b1000
    } cst_t;

    cst_t               st_reg, st_next;
    logic [4:0]         i_reg, i_next;
    logic signed [35:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] c_reg, c_next, s_reg, s_next;

    logic signed [35:0] zr, zf, xs, ys, xo;
    logic               nf;

    wide_t              zw, red_step;
    wide_t              m_reg, m_next;
    logic [4:0]         rk_reg, rk_next;

    assign zw = wide_t'(phi) <<< SH;

    always_comb begin
        st_next  = st_reg;
        i_next   = i_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        neg_next = neg_reg;
        c_next   = c_reg;
        s_next   = s_reg;
        m_next   = m_reg;
        rk_next  = rk_reg;
        red_step = '0;
        zr = '0; zf = '0; nf = 1'b0; xs = '0; ys = '0; xo = '0;
        case (st_reg)
            C_IDLE: if (start) begin
                m_next  = zw;
                rk_next = 5'(SH);
                st_next = C_RED;
            end
            C_RED: begin
                // one conditional subtract or add of 2*pi*2^k per cycle, k from SH down to 0
                red_step = wide_t'(PI_Q30) <<< (rk_reg + 5'd1);
                if (m_reg >= red_step)
                    m_next = m_reg - red_step;
                else if (m_reg < -red_step)
                    m_next = m_reg + red_step;
                if (rk_reg == 5'd0) begin
                    // m in [-2pi, 2pi): map to (-pi, pi]
                    zr = 36'(m_next);
                    if (zr < 0) zr = zr + (PI_Q30 <<< 1);
                    if (zr > PI_Q30) zr = zr - (PI_Q30 <<< 1);
                    zf = zr;
                    if (zr > (PI_Q30 >>> 1)) begin
                        zf = PI_Q30 - zr; nf = 1'b1;
                    end else if (zr < -(PI_Q30 >>> 1)) begin
                        zf = -PI_Q30 - zr; nf = 1'b1;
                    end
                    z_next   = zf;
                    neg_next = nf;
                    x_next   = KGAIN_Q30;
                    y_next   = '0;
                    i_next   = '0;
                    st_next  = C_ROT;
                end else begin
                    rk_next = rk_reg - 5'd1;
                end
            end
            C_ROT: begin
                xs = x_reg >>> i_reg;
                ys = y_reg >>> i_reg;
                if (z_reg >= 0) begin
                    x_next = x_reg - ys; y_next = y_reg + xs;
                    z_next = z_reg - atan_q30(i_reg);
                end else begin
                    x_next = x_reg + ys; y_next = y_reg - xs;
                    z_next = z_reg + atan_q30(i_reg);
                end
                i_next = i_reg + 5'd1;
                if (i_reg == 5'(STEPS - 1)) st_next = C_OUT;
            end
            C_OUT: begin
                xo = neg_reg ? -x_reg : x_reg;
                if (SH > 0) begin
                    c_next = sat32(42'((xo + (36'sd1 <<< (SH - 1))) >>> SH));
                    s_next = sat32(42'((y_reg + (36'sd1 <<< (SH - 1))) >>> SH));
                end else begin
                    c_next = sat32(42'(xo));
                    s_next = sat32(42'(y_reg));
                end
                st_next = C_IDLE;
            end
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= C_IDLE;
        end else begin
            st_reg <= st_next;
        end
        i_reg   <= i_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
        c_reg   <= c_next;
        s_reg   <= s_next;
        m_reg   <= m_next;
        rk_reg  <= rk_next;
    end

    assign done    = (st_reg == C_OUT);
    assign cos_out = c_next;
    assign sin_out = s_next;

endmodule
